// ===== hw/rtl/fca_pkg.sv =====
// Shared types and constants for the failsafe command arbiter.
`timescale 1ns / 1ps
package fca_pkg;

  localparam int NUM_SOURCES_DEF = 3;
  localparam int VALUE_BITS_DEF  = 16;
  localparam int NUM_PRIO        = 3;
  localparam int SRC_W           = 2;
  localparam int FUNC_W          = 2;
  localparam int STAMP_W         = 32;
  localparam int TIMEOUT_W       = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [SRC_W-1:0]     SRC_NONE        = 2'd3;
  localparam logic [SRC_W-1:0]     PRIO_FIRST_RST  = 2'd0;
  localparam logic [SRC_W-1:0]     PRIO_SECOND_RST = 2'd1;
  localparam logic [SRC_W-1:0]     PRIO_THIRD_RST  = 2'd2;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST     = 16'd500;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CMD   = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_TRIG  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FAILSAFE = 2'd1,
    ST_ESTOP    = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRIO_FIRST  = 2'd0,
    CFG_PRIO_SECOND = 2'd1,
    CFG_PRIO_THIRD  = 2'd2,
    CFG_TIMEOUT     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    func_t            func;
    logic [SRC_W-1:0] source;
    logic             estop;
    logic             slow;
  } req_ctl_t;

  typedef struct packed {
    logic [SRC_W-1:0] drive_src;
    logic             slow;
    status_t          status;
    logic             estop_active;
  } rsp_ctl_t;

endpackage

// ===== hw/rtl/fca_req_if.sv =====
// Request channel interface of the failsafe command arbiter.
`timescale 1ns / 1ps
interface fca_req_if #(
  parameter int VALUE_BITS = fca_pkg::VALUE_BITS_DEF
);
  import fca_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [FUNC_W-1:0]            func;
  logic [SRC_W-1:0]             source;
  logic signed [VALUE_BITS-1:0] throttle_in;
  logic signed [VALUE_BITS-1:0] steering_in;
  logic                         estop_in;
  logic                         slow_in;

  modport src (
    output valid, func, source, throttle_in, steering_in, estop_in, slow_in,
    input  ready
  );
  modport snk (
    input  valid, func, source, throttle_in, steering_in, estop_in, slow_in,
    output ready
  );
endinterface

// ===== hw/rtl/fca_rsp_if.sv =====
// Result channel interface of the failsafe command arbiter.
`timescale 1ns / 1ps
interface fca_rsp_if #(
  parameter int VALUE_BITS = fca_pkg::VALUE_BITS_DEF
);
  import fca_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [SRC_W-1:0]             drive_src;
  logic signed [VALUE_BITS-1:0] throttle_out;
  logic signed [VALUE_BITS-1:0] steering_out;
  logic                         slow_out;
  logic [1:0]                   status;
  logic                         estop_active;

  modport src (
    output valid, drive_src, throttle_out, steering_out, slow_out, status,
           estop_active,
    input  ready
  );
  modport snk (
    input  valid, drive_src, throttle_out, steering_out, slow_out, status,
           estop_active,
    output ready
  );
endinterface

// ===== hw/rtl/fca_src_table.sv =====
// Per-source command table, millisecond counter, e-stop latch and freshness check.
`timescale 1ns / 1ps
module fca_src_table #(
  parameter int NUM_SOURCES = fca_pkg::NUM_SOURCES_DEF,
  parameter int VALUE_BITS  = fca_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           advance,
  input  fca_pkg::req_ctl_t              req,
  input  logic signed [VALUE_BITS-1:0]   thr_in,
  input  logic signed [VALUE_BITS-1:0]   ste_in,
  input  logic [fca_pkg::TIMEOUT_W-1:0]  timeout,
  output logic [NUM_SOURCES-1:0]         fresh,
  output logic signed [VALUE_BITS-1:0]   thr_o [NUM_SOURCES],
  output logic signed [VALUE_BITS-1:0]   ste_o [NUM_SOURCES],
  output logic [NUM_SOURCES-1:0]         slow_o,
  output logic                           latch_o
);
  import fca_pkg::*;

  logic signed [VALUE_BITS-1:0] thr_r     [NUM_SOURCES];
  logic signed [VALUE_BITS-1:0] thr_nxt   [NUM_SOURCES];
  logic signed [VALUE_BITS-1:0] ste_r     [NUM_SOURCES];
  logic signed [VALUE_BITS-1:0] ste_nxt   [NUM_SOURCES];
  logic [STAMP_W-1:0]           stamp_r   [NUM_SOURCES];
  logic [STAMP_W-1:0]           stamp_nxt [NUM_SOURCES];
  logic [NUM_SOURCES-1:0]       slow_r, slow_nxt;
  logic [NUM_SOURCES-1:0]       eprev_r, eprev_nxt;
  logic [STAMP_W-1:0]           now_r, now_nxt;
  logic                         latch_r, latch_nxt;
  logic                         rise;

  always_comb begin
    thr_nxt   = thr_r;
    ste_nxt   = ste_r;
    stamp_nxt = stamp_r;
    slow_nxt  = slow_r;
    eprev_nxt = eprev_r;
    now_nxt   = now_r;
    latch_nxt = latch_r;
    rise      = 1'b0;
    if (advance) begin
      case (req.func)
        FUNC_CMD: begin
          for (int k = 0; k < NUM_SOURCES; k++) begin
            if (int'(req.source) == k) begin
              thr_nxt[k]   = thr_in;
              ste_nxt[k]   = ste_in;
              slow_nxt[k]  = req.slow;
              stamp_nxt[k] = now_r;
              eprev_nxt[k] = req.estop;
              if (req.estop && !eprev_r[k]) begin
                rise = 1'b1;
              end
            end
          end
          if (rise) begin
            latch_nxt = 1'b1;
          end
        end
        FUNC_TICK:  now_nxt   = now_r + STAMP_W'(1);
        FUNC_CLEAR: latch_nxt = 1'b0;
        FUNC_TRIG:  latch_nxt = 1'b1;
        default:    latch_nxt = latch_r;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_SOURCES; k++) begin
      fresh[k] = (now_nxt - stamp_nxt[k]) < STAMP_W'(timeout);
    end
  end

  assign thr_o   = thr_nxt;
  assign ste_o   = ste_nxt;
  assign slow_o  = slow_nxt;
  assign latch_o = latch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_SOURCES; k++) begin
        thr_r[k]   <= '0;
        ste_r[k]   <= '0;
        stamp_r[k] <= '0;
      end
      slow_r  <= '0;
      eprev_r <= '0;
      now_r   <= '0;
      latch_r <= 1'b0;
    end else begin
      thr_r   <= thr_nxt;
      ste_r   <= ste_nxt;
      stamp_r <= stamp_nxt;
      slow_r  <= slow_nxt;
      eprev_r <= eprev_nxt;
      now_r   <= now_nxt;
      latch_r <= latch_nxt;
    end
  end

endmodule

// ===== hw/rtl/fca_select.sv =====
// Priority selection of the first fresh source and result formation.
`timescale 1ns / 1ps
module fca_select #(
  parameter int NUM_SOURCES = fca_pkg::NUM_SOURCES_DEF,
  parameter int VALUE_BITS  = fca_pkg::VALUE_BITS_DEF
) (
  input  logic [fca_pkg::SRC_W-1:0]    prio [fca_pkg::NUM_PRIO],
  input  logic [NUM_SOURCES-1:0]       fresh,
  input  logic signed [VALUE_BITS-1:0] thr [NUM_SOURCES],
  input  logic signed [VALUE_BITS-1:0] ste [NUM_SOURCES],
  input  logic [NUM_SOURCES-1:0]       slow,
  input  logic                         latch,
  output fca_pkg::rsp_ctl_t            ctl,
  output logic signed [VALUE_BITS-1:0] thr_out,
  output logic signed [VALUE_BITS-1:0] ste_out
);
  import fca_pkg::*;

  logic                   found;
  logic [NUM_SOURCES-1:0] pick;

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int p = 0; p < NUM_PRIO; p++) begin
      for (int k = 0; k < NUM_SOURCES; k++) begin
        if (!found && int'(prio[p]) == k && fresh[k]) begin
          found   = 1'b1;
          pick[k] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    ctl.drive_src    = SRC_NONE;
    ctl.slow         = 1'b0;
    ctl.status       = ST_FAILSAFE;
    ctl.estop_active = latch;
    thr_out          = '0;
    ste_out          = '0;
    if (latch) begin
      ctl.status = ST_ESTOP;
    end else if (found) begin
      ctl.status = ST_OK;
      for (int k = 0; k < NUM_SOURCES; k++) begin
        if (pick[k]) begin
          ctl.drive_src = SRC_W'(k);
          ctl.slow      = slow[k];
          thr_out       = thr[k];
          ste_out       = ste[k];
        end
      end
    end
  end

endmodule

// ===== hw/rtl/failsafe_command_arbiter.sv =====
// Top level: holds the latest command per source and reports the arbitrated drive output.
// A request is held in the request register; its result is then written to the result register when not stalled.
// Throughput: one request per cycle while the result is not stalled; the state update and age compares share one stage.
// A stalled result stalls the request register, which still takes a request when it is empty.
// Reset (synchronous, active low) clears the command table, ms counter, e-stop latch
// and pipeline, and loads the priority slots 0, 1, 2 and a 500 ms timeout.
`timescale 1ns / 1ps
module failsafe_command_arbiter #(
  parameter int NUM_SOURCES = fca_pkg::NUM_SOURCES_DEF,
  parameter int VALUE_BITS  = fca_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fca_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fca_pkg::CFG_DATA_W-1:0] cfg_wdata,
  fca_req_if.snk                         in_ch,
  fca_rsp_if.src                         out_ch
);
  import fca_pkg::*;

  logic [SRC_W-1:0]             prio_r [NUM_PRIO];
  logic [TIMEOUT_W-1:0]         timeout_r;

  logic                         req_vld_r;
  req_ctl_t                     req_ctl_r;
  logic signed [VALUE_BITS-1:0] req_thr_r;
  logic signed [VALUE_BITS-1:0] req_ste_r;

  logic                         out_vld_r;
  rsp_ctl_t                     out_ctl_r;
  logic signed [VALUE_BITS-1:0] out_thr_r;
  logic signed [VALUE_BITS-1:0] out_ste_r;

  logic                         stall;
  logic                         advance;
  logic                         in_take;

  logic [NUM_SOURCES-1:0]       fresh;
  logic signed [VALUE_BITS-1:0] tab_thr [NUM_SOURCES];
  logic signed [VALUE_BITS-1:0] tab_ste [NUM_SOURCES];
  logic [NUM_SOURCES-1:0]       tab_slow;
  logic                         latch;
  rsp_ctl_t                     sel_ctl;
  logic signed [VALUE_BITS-1:0] sel_thr;
  logic signed [VALUE_BITS-1:0] sel_ste;

  assign stall       = out_vld_r && !out_ch.ready;
  assign advance     = req_vld_r && !stall;
  assign in_ch.ready = !req_vld_r || !stall;
  assign in_take     = in_ch.valid && in_ch.ready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_r[0] <= PRIO_FIRST_RST;
      prio_r[1] <= PRIO_SECOND_RST;
      prio_r[2] <= PRIO_THIRD_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_PRIO_FIRST:  prio_r[0] <= cfg_wdata[SRC_W-1:0];
        CFG_PRIO_SECOND: prio_r[1] <= cfg_wdata[SRC_W-1:0];
        CFG_PRIO_THIRD:  prio_r[2] <= cfg_wdata[SRC_W-1:0];
        CFG_TIMEOUT:     timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        default:         timeout_r <= timeout_r;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      req_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_ctl_r.func   <= func_t'(in_ch.func);
      req_ctl_r.source <= in_ch.source;
      req_ctl_r.estop  <= in_ch.estop_in;
      req_ctl_r.slow   <= in_ch.slow_in;
      req_thr_r        <= in_ch.throttle_in;
      req_ste_r        <= in_ch.steering_in;
    end
  end

  fca_src_table #(
    .NUM_SOURCES (NUM_SOURCES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .req     (req_ctl_r),
    .thr_in  (req_thr_r),
    .ste_in  (req_ste_r),
    .timeout (timeout_r),
    .fresh   (fresh),
    .thr_o   (tab_thr),
    .ste_o   (tab_ste),
    .slow_o  (tab_slow),
    .latch_o (latch)
  );

  fca_select #(
    .NUM_SOURCES (NUM_SOURCES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_select (
    .prio    (prio_r),
    .fresh   (fresh),
    .thr     (tab_thr),
    .ste     (tab_ste),
    .slow    (tab_slow),
    .latch   (latch),
    .ctl     (sel_ctl),
    .thr_out (sel_thr),
    .ste_out (sel_ste)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!stall) begin
      out_vld_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ctl_r <= sel_ctl;
      out_thr_r <= sel_thr;
      out_ste_r <= sel_ste;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.drive_src    = out_ctl_r.drive_src;
  assign out_ch.throttle_out = out_thr_r;
  assign out_ch.steering_out = out_ste_r;
  assign out_ch.slow_out     = out_ctl_r.slow;
  assign out_ch.status       = out_ctl_r.status;
  assign out_ch.estop_active = out_ctl_r.estop_active;

endmodule

// ===== dv/fca_drive_checker.sv =====
// Checker for the failsafe command arbiter: tracks requests, predicts drive results, compares.
`timescale 1ns / 1ps
module fca_drive_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fca_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fca_pkg::CFG_DATA_W-1:0] cfg_wdata,
  fca_req_if                             req,
  fca_rsp_if                             rsp,
  output int                             mismatches,
  output int                             outstanding,
  output int                             checked
);
  import fca_pkg::*;

  localparam int NS = NUM_SOURCES_DEF;
  localparam int VB = VALUE_BITS_DEF;

  typedef struct {
    logic [SRC_W-1:0]     source;
    logic signed [VB-1:0] throttle;
    logic signed [VB-1:0] steering;
    logic                 slow;
    status_t              status;
    logic                 estop;
  } drive_t;

  logic signed [VB-1:0] held_thr   [NS];
  logic signed [VB-1:0] held_ste   [NS];
  logic                 held_slow  [NS];
  logic                 held_estop [NS];
  logic [STAMP_W-1:0]   held_stamp [NS];
  logic [STAMP_W-1:0]   ms_count;
  logic                 stop_latched;
  status_t              health;
  logic [SRC_W-1:0]     prio_slot [NUM_PRIO];
  logic [TIMEOUT_W-1:0] stale_ms;
  drive_t               drive_q [$];

  function automatic logic [SRC_W-1:0] freshest_source();
    logic [SRC_W-1:0] s;
    for (int i = 0; i < NUM_PRIO; i++) begin
      s = prio_slot[i];
      if (s < NS && (ms_count - held_stamp[s]) < STAMP_W'(stale_ms))
        return s;
    end
    return SRC_NONE;
  endfunction

  function automatic drive_t arbitrate();
    drive_t d;
    logic [SRC_W-1:0] s;
    d.source = SRC_NONE;
    d.throttle = '0;
    d.steering = '0;
    d.slow = 1'b0;
    if (!stop_latched) begin
      s = freshest_source();
      if (s != SRC_NONE) begin
        d.source = s;
        d.throttle = held_thr[s];
        d.steering = held_ste[s];
        d.slow = held_slow[s];
        if (health == ST_FAILSAFE)
          health = ST_OK;
      end else begin
        health = ST_FAILSAFE;
      end
    end
    d.estop = stop_latched;
    d.status = stop_latched ? ST_ESTOP : health;
    return d;
  endfunction

  function automatic void take_request();
    drive_t d;
    logic [SRC_W-1:0] s;
    s = req.source;
    case (func_t'(req.func))
      FUNC_CMD: begin
        if (s < NS) begin
          held_thr[s] = req.throttle_in;
          held_ste[s] = req.steering_in;
          held_slow[s] = req.slow_in;
          held_stamp[s] = ms_count;
          if (req.estop_in && !held_estop[s]) begin
            stop_latched = 1'b1;
            health = ST_ESTOP;
          end
          held_estop[s] = req.estop_in;
        end
      end
      FUNC_TICK: ms_count = ms_count + 1;
      FUNC_CLEAR: begin
        stop_latched = 1'b0;
        d = arbitrate();
        health = (d.source == SRC_NONE) ? ST_FAILSAFE : ST_OK;
      end
      default: begin
        stop_latched = 1'b1;
        health = ST_ESTOP;
      end
    endcase
    drive_q.push_back(arbitrate());
  endfunction

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    drive_t want;
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        held_thr[i] = '0;
        held_ste[i] = '0;
        held_slow[i] = 1'b0;
        held_estop[i] = 1'b0;
        held_stamp[i] = '0;
      end
      ms_count = '0;
      stop_latched = 1'b0;
      health = ST_OK;
      prio_slot[0] = PRIO_FIRST_RST;
      prio_slot[1] = PRIO_SECOND_RST;
      prio_slot[2] = PRIO_THIRD_RST;
      stale_ms = TIMEOUT_RST;
      drive_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx_t'(cfg_idx) == CFG_TIMEOUT)
          stale_ms = cfg_wdata;
        else
          prio_slot[cfg_idx] = cfg_wdata[SRC_W-1:0];
      end
      if (req.valid && req.ready)
        take_request();
      if (rsp.valid && rsp.ready) begin
        if (drive_q.size() == 0) begin
          mismatches++;
          $display("%0t: drive result with nothing pending, expected none, got source %0d",
                   $time, rsp.drive_src);
        end else begin
          want = drive_q.pop_front();
          compare_field("drive_src", want.source, rsp.drive_src);
          compare_field("throttle_out", want.throttle, rsp.throttle_out);
          compare_field("steering_out", want.steering, rsp.steering_out);
          compare_field("slow_out", want.slow, rsp.slow_out);
          compare_field("status", want.status, rsp.status);
          compare_field("estop_active", want.estop, rsp.estop_active);
          checked++;
        end
      end
    end
    outstanding <= drive_q.size();
  end
endmodule

// ===== dv/failsafe_command_arbiter_test.sv =====
// Testbench top for the failsafe command arbiter: stimulus, reset, config phases and verdict.
`timescale 1ns / 1ps
module failsafe_command_arbiter_test;
  import fca_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 170;

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PATTERN, SINK_SPARSE} sink_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_idx = CFG_PRIO_FIRST;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                  r_valid = 1'b0;
  func_t                 r_func = FUNC_TICK;
  logic [SRC_W-1:0]      r_source = '0;
  logic signed [15:0]    r_thr = '0;
  logic signed [15:0]    r_ste = '0;
  logic                  r_estop = 1'b0;
  logic                  r_slow = 1'b0;
  logic                  sink_ready = 1'b0;

  int mismatches;
  int outstanding;
  int checked;
  int sent = 0;
  int settings = 0;
  int burst_left = 0;
  int gap_max = 4;
  int cycles = 0;

  sink_mode_t  sink_mode = SINK_OPEN;
  int          sink_left = 0;
  logic [15:0] sink_mask = '1;

  fca_req_if req_ch ();
  fca_rsp_if rsp_ch ();

  assign req_ch.valid       = r_valid;
  assign req_ch.func        = r_func;
  assign req_ch.source      = r_source;
  assign req_ch.throttle_in = r_thr;
  assign req_ch.steering_in = r_ste;
  assign req_ch.estop_in    = r_estop;
  assign req_ch.slow_in     = r_slow;
  assign rsp_ch.ready       = sink_ready;

  failsafe_command_arbiter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch)
  );

  fca_drive_checker drive_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_mask = 16'($urandom);
      sink_left = $urandom_range(20, 80);
    end
    sink_left--;
    case (sink_mode)
      SINK_OPEN:    sink_ready <= 1'b1;
      SINK_RANDOM:  sink_ready <= ($urandom_range(0, 3) != 0);
      SINK_PATTERN: sink_ready <= sink_mask[sink_left % 16];
      default:      sink_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  task automatic send(input func_t f, input logic [SRC_W-1:0] s, input logic [15:0] t,
                      input logic [15:0] st, input logic e, input logic sl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        r_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    r_valid  <= 1'b1;
    r_func   <= f;
    r_source <= s;
    r_thr    <= t;
    r_ste    <= st;
    r_estop  <= e;
    r_slow   <= sl;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  task automatic drain();
    r_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic program_arbiter(input logic [SRC_W-1:0] p0, input logic [SRC_W-1:0] p1,
                                 input logic [SRC_W-1:0] p2, input logic [15:0] tmo);
    cfg_idx_t sel;
    drain();
    for (int i = 0; i < 4; i++) begin
      sel = cfg_idx_t'(i);
      cfg_we  <= 1'b1;
      cfg_idx <= sel;
      case (sel)
        CFG_PRIO_FIRST:  cfg_wdata <= CFG_DATA_W'(p0);
        CFG_PRIO_SECOND: cfg_wdata <= CFG_DATA_W'(p1);
        CFG_PRIO_THIRD:  cfg_wdata <= CFG_DATA_W'(p2);
        default:         cfg_wdata <= tmo;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic logic [15:0] drive_value();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [SRC_W-1:0] random_slot();
    return ($urandom_range(0, 9) == 0) ? SRC_NONE : SRC_W'($urandom_range(0, 2));
  endfunction

  task automatic random_request();
    int roll;
    func_t f;
    logic [SRC_W-1:0] s;
    roll = $urandom_range(0, 99);
    if (roll < 48)
      f = FUNC_CMD;
    else if (roll < 88)
      f = FUNC_TICK;
    else if (roll < 95)
      f = FUNC_CLEAR;
    else
      f = FUNC_TRIG;
    s = ($urandom_range(0, 19) == 0) ? SRC_NONE : SRC_W'($urandom_range(0, 2));
    send(f, s, drive_value(), drive_value(), ($urandom_range(0, 11) == 0),
         1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [SRC_W-1:0] p0, p1, p2;
    logic [15:0] tmo;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send(FUNC_CMD,   2'd0,     16'h7FFF, 16'h8000, 1'b0, 1'b1);
    send(FUNC_CMD,   2'd1,     16'h8000, 16'h7FFF, 1'b0, 1'b0);
    send(FUNC_CMD,   2'd2,     16'hFFFF, 16'h0001, 1'b0, 1'b1);
    send(FUNC_CMD,   SRC_NONE, 16'h1234, 16'h4321, 1'b1, 1'b1);
    send(FUNC_TICK,  2'd0,     16'h0000, 16'h0000, 1'b0, 1'b0);
    send(FUNC_CMD,   2'd1,     16'h0000, 16'h0000, 1'b1, 1'b0);
    send(FUNC_CMD,   2'd1,     16'h5555, 16'hAAAA, 1'b1, 1'b1);
    send(FUNC_CLEAR, 2'd0,     16'h0000, 16'h0000, 1'b0, 1'b0);
    send(FUNC_CMD,   2'd1,     16'hAAAA, 16'h5555, 1'b1, 1'b0);
    send(FUNC_CMD,   2'd1,     16'h0100, 16'hFF00, 1'b0, 1'b1);
    send(FUNC_TRIG,  2'd2,     16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    send(FUNC_TICK,  2'd1,     16'h0000, 16'h0000, 1'b0, 1'b0);
    send(FUNC_CLEAR, 2'd0,     16'h0000, 16'h0000, 1'b0, 1'b0);

    program_arbiter(2'd2, 2'd1, 2'd0, 16'd1);
    send(FUNC_TICK,  2'd0,     16'h0000, 16'h0000, 1'b0, 1'b0);
    send(FUNC_CMD,   2'd2,     16'h4000, 16'hC000, 1'b0, 1'b1);
    send(FUNC_TICK,  2'd0,     16'h0000, 16'h0000, 1'b0, 1'b0);
    send(FUNC_CLEAR, 2'd0,     16'h0000, 16'h0000, 1'b0, 1'b0);
    send(FUNC_CMD,   2'd0,     16'h0001, 16'hFFFE, 1'b0, 1'b0);
    send(FUNC_TRIG,  2'd0,     16'h0000, 16'h0000, 1'b0, 1'b0);
    send(FUNC_CLEAR, 2'd0,     16'h0000, 16'h0000, 1'b0, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      p0 = random_slot();
      p1 = random_slot();
      p2 = random_slot();
      case (ph)
        0:       tmo = 16'd0;
        1:       tmo = 16'hFFFF;
        2: begin
          tmo = 16'd1;
          p0 = SRC_NONE;
          p2 = SRC_NONE;
        end
        3: begin
          tmo = 16'd8;
          p0 = SRC_NONE;
          p1 = SRC_NONE;
          p2 = SRC_NONE;
        end
        default: tmo = 16'($urandom_range(1, 30));
      endcase
      program_arbiter(p0, p1, p2, tmo);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
      repeat (PHASE_ITEMS) random_request();
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests (commands, ticks, clears, triggers) over %0d arbiter settings;",
             sent, settings);
    $display("%0d drive results compared field by field.", checked);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/fca_pkg.sv
hw/rtl/fca_req_if.sv
hw/rtl/fca_rsp_if.sv
hw/rtl/fca_src_table.sv
hw/rtl/fca_select.sv
hw/rtl/failsafe_command_arbiter.sv
dv/fca_drive_checker.sv
dv/failsafe_command_arbiter_test.sv
